### design/link_state_route_engine_assert.svh
// Assertion macros used by the checker file.
`ifndef LINK_STATE_ROUTE_ENGINE_ASSERT_SVH
`define LINK_STATE_ROUTE_ENGINE_ASSERT_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define LSRE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define LSRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/lsre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsre_pkg
// Shared types and constants of the link state route engine.
// ----------------------------------------------------------------------------
package lsre_pkg;

  localparam int MAX_NODES_D = 32;
  localparam int MAX_EDGES_D = 256;
  localparam int MAX_PORTS_D = 16;

  localparam logic [15:0] INF_COST = 16'hFFFF;

  localparam logic [1:0] KIND_LOCAL   = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_LINK    = 2'd2;
  localparam logic [1:0] KIND_COMPUTE = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OWN   = 3'd1;
  localparam logic [2:0] ST_HEARD = 3'd2;
  localparam logic [2:0] ST_PORT  = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  localparam logic CFG_SELF  = 1'b0;
  localparam logic CFG_PORTS = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  port;
    logic [15:0] peer_addr;
    logic [15:0] link_cost;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  status;
    logic [15:0] forward_mask;
    logic [15:0] dest_addr;
    logic [15:0] path_cost;
    logic [5:0]  hop_total;
    logic [15:0] first_hop;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SCAN,
    BK_HDR_DONE,
    BK_CLR,
    BK_ENTER_LOOK,
    BK_ENTER_CMP,
    BK_WALK_RD,
    BK_WALK_CHK,
    BK_STEP_RD,
    BK_STEP_CHK,
    BK_EMIT_RD,
    BK_EMIT
  } bk_state_t;

endpackage
`default_nettype wire

### design/lsre_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsre_stream_if
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface lsre_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/link_state_route_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// link_state_route_engine
// Link state table with LSA flooding checks and route search.
// ----------------------------------------------------------------------------
// Link items leave the queue one per cycle while the engine is idle and the
// output is free, and any verdict is registered on that cycle, so it passes
// the queue entry and the output register. A header first scans the heard
// memory for a duplicate. A compute item clears the best entries of heard
// nodes, then runs a depth-first search: each edge entry of a frame's walk
// passes WALK_CHK and STEP_CHK, every step rescans the table from the top for
// its pair weight at one entry per cycle and looks up the neighbor's heard
// index at one entry per cycle, then route entries leave via EMIT_RD and EMIT
// while the output is free. The two-entry front queue takes inputs until full.
module link_state_route_engine
  import lsre_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_D,
  parameter int MAX_EDGES = MAX_EDGES_D,
  parameter int MAX_PORTS = MAX_PORTS_D
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  lsre_stream_if.sink      in_ch,
  lsre_stream_if.source    out_ch
);

  logic [15:0] self_r;
  logic [4:0]  ports_r;
  logic        q_valid, q_pop;
  in_item_t    q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_r  <= '0;
      ports_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SELF:  self_r  <= cfg_data;
        CFG_PORTS: ports_r <= cfg_data[4:0];
        default:   ;
      endcase
    end
  end

  lsre_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  lsre_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .MAX_PORTS(MAX_PORTS))
  u_back (
    .clk(clk), .rst_n(rst_n), .self_addr(self_r), .num_ports(ports_r),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

endmodule
`default_nettype wire

### design/lsre_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsre_front
// Input stage and two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module lsre_front
  import lsre_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          q_valid,
  input  wire logic     q_pop,
  output in_item_t      q_data
);

  in_item_t   buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

### design/lsre_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsre_back
// Table keeper and route search sequencer with a registered output stage.
// ----------------------------------------------------------------------------
module lsre_back
  import lsre_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_D,
  parameter int MAX_EDGES = MAX_EDGES_D,
  parameter int MAX_PORTS = MAX_PORTS_D
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [15:0] self_addr,
  input  wire logic [4:0]  num_ports,
  input  wire logic      q_valid,
  input  wire in_item_t  q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam logic [NW:0] NODES_N = (NW+1)'(MAX_NODES);
  localparam logic [EW:0] EDGES_N = (EW+1)'(MAX_EDGES);
  localparam logic [4:0]  PORTS_N = 5'(MAX_PORTS);

  // edge table memory, one read port
  logic [47:0] edge_mem [MAX_EDGES];
  logic [47:0] edge_rd_r;
  logic        edge_we;
  logic [EW-1:0] edge_wa, edge_ra;
  logic [47:0] edge_wd;

  // per-node memories
  logic [15:0] heard_mem [MAX_NODES];
  logic [15:0] heard_rd_r;
  logic        heard_we;
  logic [NW-1:0] heard_wa, heard_ra;
  logic [37:0] best_mem [MAX_NODES];
  logic [37:0] best_rd_r;
  logic        best_we;
  logic [NW-1:0] best_wa, best_ra;
  logic [37:0] best_wd;
  // stack: node, cost, hops, first, cursor
  logic [54+EW:0] stk_mem [MAX_NODES];
  logic [54+EW:0] stk_rd_r;
  logic        stk_we;
  logic [NW-1:0] stk_wa, stk_ra;
  logic [54+EW:0] stk_wd;

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_rd_r <= edge_mem[edge_ra];
    if (heard_we) heard_mem[heard_wa] <= q_data.peer_addr;
    heard_rd_r <= heard_mem[heard_ra];
    if (best_we) best_mem[best_wa] <= best_wd;
    best_rd_r <= best_mem[best_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stk_mem[stk_ra];
  end

  bk_state_t st_r, st_nxt;
  logic [EW:0]  ecnt_r, ecnt_nxt;
  logic [NW:0]  hcnt_r, hcnt_nxt;
  logic         open_r, open_nxt;
  logic [15:0]  osnd_r, osnd_nxt;
  logic [NW:0]  idx_r, idx_nxt;     // scan/clear/emit index
  logic [EW:0]  eidx_r, eidx_nxt;   // edge walk index
  logic [NW:0]  sp_r, sp_nxt;       // stack depth
  logic         found_r, found_nxt;
  // candidate to enter
  logic [15:0]  cn_r, cn_nxt, cc_r, cc_nxt, cf_r, cf_nxt;
  logic [5:0]   ch_r, ch_nxt;
  logic [NW-1:0] cidx_r, cidx_nxt;
  // top frame copy
  logic [15:0]  tn_r, tn_nxt, tc_r, tc_nxt, tf_r, tf_nxt, nb_r, nb_nxt;
  logic [5:0]   th_r, th_nxt;
  logic         ov_r, ov_nxt;
  out_item_t    od_r, od_nxt;

  logic [15:0] heard_val;
  logic [4:0]  ports;
  logic [15:0] mask;
  logic [16:0] csum;
  logic        can_out;

  assign heard_val = (idx_r == '0) ? self_addr : heard_rd_r;
  assign ports     = (num_ports > PORTS_N) ? PORTS_N : num_ports;
  assign can_out   = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    mask = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < ports && 4'(i) != q_data.port) mask[i] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      ecnt_r <= '0;
      hcnt_r <= (NW+1)'(1);
      open_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ecnt_r <= ecnt_nxt;
      hcnt_r <= hcnt_nxt;
      open_r <= open_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    osnd_r <= osnd_nxt; idx_r <= idx_nxt; eidx_r <= eidx_nxt; sp_r <= sp_nxt;
    found_r <= found_nxt; cn_r <= cn_nxt; cc_r <= cc_nxt; cf_r <= cf_nxt;
    ch_r <= ch_nxt; cidx_r <= cidx_nxt; tn_r <= tn_nxt; tc_r <= tc_nxt;
    tf_r <= tf_nxt; th_r <= th_nxt; nb_r <= nb_nxt; od_r <= od_nxt;
  end

  always_comb begin
    st_nxt = st_r; ecnt_nxt = ecnt_r; hcnt_nxt = hcnt_r; open_nxt = open_r;
    osnd_nxt = osnd_r; idx_nxt = idx_r; eidx_nxt = eidx_r; sp_nxt = sp_r;
    found_nxt = found_r; cn_nxt = cn_r; cc_nxt = cc_r; cf_nxt = cf_r;
    ch_nxt = ch_r; cidx_nxt = cidx_r; tn_nxt = tn_r; tc_nxt = tc_r;
    tf_nxt = tf_r; th_nxt = th_r; nb_nxt = nb_r;
    ov_nxt = ov_r && !out_ready; od_nxt = od_r;
    q_pop = 1'b0;
    edge_we = 1'b0; edge_wa = ecnt_r[EW-1:0];
    edge_wd = {q_data.link_cost, q_data.peer_addr, self_addr};
    edge_ra = eidx_r[EW-1:0];
    heard_we = 1'b0; heard_wa = hcnt_r[NW-1:0]; heard_ra = idx_r[NW-1:0];
    best_we = 1'b0; best_wa = cidx_r; best_wd = {INF_COST, 6'd0, 16'd0};
    best_ra = cidx_r;
    stk_we = 1'b0; stk_wa = sp_r[NW-1:0]; stk_ra = sp_r[NW-1:0] - 1'b1;
    stk_wd = {cn_r, cc_r, ch_r, cf_r, {(EW+1){1'b0}}};
    csum = {1'b0, tc_r} + {1'b0, edge_rd_r[47:32]};

    unique case (st_r)
      BK_IDLE: begin
        if (q_valid && can_out) begin
          unique case (q_data.kind)
            KIND_LOCAL, KIND_LINK: begin
              q_pop = 1'b1;
              if (q_data.kind == KIND_LOCAL) open_nxt = 1'b0;
              if (q_data.kind == KIND_LOCAL || open_r) begin
                od_nxt = '0;
                ov_nxt = 1'b1;
                if (ecnt_r >= EDGES_N) begin
                  od_nxt.status = ST_FULL;
                end else begin
                  edge_we = 1'b1;
                  if (q_data.kind == KIND_LINK)
                    edge_wd = {q_data.link_cost, q_data.peer_addr, osnd_r};
                  ecnt_nxt = ecnt_r + 1'b1;
                end
              end
            end
            KIND_HEADER: begin
              open_nxt = 1'b0;
              idx_nxt = '0; found_nxt = 1'b0;
              heard_ra = '0;
              st_nxt = BK_SCAN;
            end
            default: begin
              open_nxt = 1'b0;
              idx_nxt = '0; cidx_nxt = '0;
              st_nxt = BK_CLR;
            end
          endcase
        end
      end
      // one heard entry per cycle; read data for idx_r ready now
      BK_SCAN: begin
        if (heard_val == q_data.peer_addr) found_nxt = 1'b1;
        idx_nxt = idx_r + 1'b1;
        heard_ra = idx_nxt[NW-1:0];
        if (idx_nxt >= hcnt_r) st_nxt = BK_HDR_DONE;
      end
      BK_HDR_DONE: begin
        q_pop = 1'b1;
        od_nxt = '0;
        ov_nxt = 1'b1;
        priority if (q_data.peer_addr == self_addr) od_nxt.status = ST_OWN;
        else if (found_r) od_nxt.status = ST_HEARD;
        else if ({1'b0, q_data.port} >= ports) od_nxt.status = ST_PORT;
        else if (hcnt_r >= NODES_N) od_nxt.status = ST_FULL;
        else begin
          heard_we = 1'b1;
          hcnt_nxt = hcnt_r + 1'b1;
          open_nxt = 1'b1;
          osnd_nxt = q_data.peer_addr;
          od_nxt.forward_mask = mask;
        end
        st_nxt = BK_IDLE;
      end
      BK_CLR: begin
        best_we = 1'b1;
        best_wa = idx_r[NW-1:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt >= hcnt_r) begin
          sp_nxt = '0;
          cn_nxt = self_addr; cc_nxt = '0; ch_nxt = '0; cf_nxt = '0;
          idx_nxt = '0; heard_ra = '0;
          st_nxt = BK_ENTER_LOOK;
        end
      end
      // find heard index of cn_r, one entry per cycle
      BK_ENTER_LOOK: begin
        if (idx_r >= hcnt_r) begin
          st_nxt = BK_WALK_RD;
        end else if (heard_val == cn_r) begin
          cidx_nxt = idx_r[NW-1:0];
          st_nxt = BK_ENTER_CMP;
        end else begin
          idx_nxt = idx_r + 1'b1;
          heard_ra = idx_nxt[NW-1:0];
        end
      end
      BK_ENTER_CMP: begin
        // best_rd_r holds entry cidx_r (read issued last cycle)
        if (best_rd_r[37:22] > cc_r && sp_r < NODES_N) begin
          best_we = 1'b1;
          best_wd = {cc_r, ch_r, cf_r};
          stk_we = 1'b1;
          sp_nxt = sp_r + 1'b1;
          tn_nxt = cn_r; tc_nxt = cc_r; th_nxt = ch_r; tf_nxt = cf_r;
          eidx_nxt = '0;
          st_nxt = BK_WALK_CHK;
        end else begin
          st_nxt = BK_WALK_RD;
        end
      end
      // reload top frame after a pop or failed enter, or start emitting once the stack is empty
      BK_WALK_RD: begin
        if (sp_r == '0) begin
          idx_nxt = '0; heard_ra = '0;
          st_nxt = BK_EMIT_RD;
        end else begin
          st_nxt = BK_STEP_RD;
          found_nxt = 1'b1;
        end
      end
      BK_STEP_RD: begin
        // stk_rd_r valid
        if (found_r) begin
          {tn_nxt, tc_nxt, th_nxt, tf_nxt, eidx_nxt} = stk_rd_r;
          found_nxt = 1'b0;
        end
        st_nxt = BK_WALK_CHK;
      end
      BK_WALK_CHK: begin
        if (eidx_r >= ecnt_r) begin
          sp_nxt = sp_r - 1'b1;
          stk_ra = sp_nxt[NW-1:0] - 1'b1;
          st_nxt = BK_WALK_RD;
        end else begin
          st_nxt = BK_STEP_CHK;
          idx_nxt = '0;
        end
      end
      BK_STEP_CHK: begin
        // edge_rd_r holds entry eidx_r
        if (idx_r == '0 && edge_rd_r[15:0] != tn_r) begin
          eidx_nxt = eidx_r + 1'b1;
          edge_ra = eidx_nxt[EW-1:0];
          st_nxt = BK_WALK_CHK;
        end else if (idx_r == '0) begin
          // matching edge: note the target, then look for first same pair
          nb_nxt = edge_rd_r[31:16];
          idx_nxt = (NW+1)'(1);
          stk_we = 1'b1;
          stk_wa = sp_r[NW-1:0] - 1'b1;
          stk_wd = {tn_r, tc_r, th_r, tf_r, eidx_r + 1'b1};
          eidx_nxt = '0;
          edge_ra = '0;
          cidx_nxt = '0;
        end else if (edge_rd_r[15:0] == tn_r && edge_rd_r[31:16] == nb_r) begin
          // first (source, target) match gives the step weight
          cn_nxt = nb_r;
          cc_nxt = csum[16] ? INF_COST : csum[15:0];
          ch_nxt = th_r + 1'b1;
          cf_nxt = (th_r == '0) ? nb_r : tf_r;
          idx_nxt = '0; heard_ra = '0;
          st_nxt = BK_ENTER_LOOK;
        end else begin
          eidx_nxt = eidx_r + 1'b1;
          edge_ra = eidx_nxt[EW-1:0];
        end
      end
      BK_EMIT_RD: begin
        best_ra = idx_r[NW-1:0];
        st_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        // hold the read of this entry while the output is stalled
        best_ra = idx_r[NW-1:0];
        if (can_out) begin
          od_nxt = '0;
          od_nxt.result_kind = 1'b1;
          od_nxt.dest_addr = heard_val;
          od_nxt.path_cost = best_rd_r[37:22];
          if (best_rd_r[37:22] != INF_COST) begin
            od_nxt.hop_total = best_rd_r[21:16];
            if (best_rd_r[21:16] != '0) od_nxt.first_hop = best_rd_r[15:0];
          end
          ov_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
          heard_ra = idx_nxt[NW-1:0];
          if (idx_nxt >= hcnt_r) begin
            od_nxt.last = 1'b1;
            q_pop = 1'b1;
            st_nxt = BK_IDLE;
          end else begin
            st_nxt = BK_EMIT_RD;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
    // the best read for ENTER_CMP is addressed by idx_r, the heard index just found
    if (st_nxt == BK_ENTER_CMP) best_ra = idx_r[NW-1:0];
  end

endmodule
`default_nettype wire

### design/lsre_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "link_state_route_engine_assert.svh"
// ----------------------------------------------------------------------------
// lsre_checker
// Port-level checks of the result stream.
// ----------------------------------------------------------------------------
module lsre_checker
  import lsre_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_item_t out_data
);
  `LSRE_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `LSRE_ASSERT_IMP(a_verdict_clean, clk, rst_n, out_valid && !out_data.result_kind, out_data.dest_addr == 16'd0 && out_data.last == 1'b0, "verdict carries route fields")
  `LSRE_ASSERT_IMP(a_route_status, clk, rst_n, out_valid && out_data.result_kind, out_data.status == ST_OK && out_data.forward_mask == 16'd0, "route carries verdict fields")
  `LSRE_ASSERT_IMP(a_mask_ok, clk, rst_n, out_valid && out_data.forward_mask != 16'd0, out_data.status == ST_OK, "mask on rejected header")
endmodule

bind link_state_route_engine lsre_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
`default_nettype wire

### tb/sv/tb_link_state_route_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_link_state_route_engine
// Drives local links, LSA headers, LSA links and route computes into the
// engine, predicts every verdict and route entry from a behavioral model of
// the edge table, heard list and pruned depth-first search, and checks the
// results in order under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_link_state_route_engine;
  import lsre_pkg::*;

  localparam int NODES = MAX_NODES_D;
  localparam int EDGES = MAX_EDGES_D;
  localparam int PORTS = MAX_PORTS_D;
  localparam int STALL_LIMIT = 1000000;
  localparam int SEARCH_BUDGET = 60000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;

  lsre_stream_if #(.payload_t(in_item_t)) in_ch ();
  lsre_stream_if #(.payload_t(out_item_t)) out_ch ();

  link_state_route_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Model state
  logic [15:0] self_addr;
  logic [4:0]  port_count;
  logic [15:0] edge_src [EDGES];
  logic [15:0] edge_dst [EDGES];
  logic [15:0] edge_w   [EDGES];
  int          edge_total;
  logic [15:0] heard [NODES];
  int          heard_total;
  bit          lsa_is_open;
  logic [15:0] lsa_sender;

  // Search scratch
  logic [15:0] best_c [NODES];
  int          best_h [NODES];
  logic [15:0] best_f [NODES];
  logic [15:0] stk_node [NODES];
  logic [15:0] stk_cost [NODES];
  int          stk_hops [NODES];
  logic [15:0] stk_first [NODES];
  int          stk_cursor [NODES];
  int          stk_depth;

  out_item_t expected_results[$];
  int mismatches;
  int send_gap_pct;
  int recv_stall_pct;
  int cycle_count;
  int hold_until;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] heard_at(int i);
    return (i == 0) ? self_addr : heard[i];
  endfunction

  function automatic int find_heard(logic [15:0] a);
    for (int i = 0; i < heard_total; i++) begin
      if (heard_at(i) == a) return i;
    end
    return -1;
  endfunction

  function automatic logic [15:0] pair_weight(logic [15:0] from, logic [15:0] to);
    for (int i = 0; i < edge_total; i++) begin
      if (edge_src[i] == from && edge_dst[i] == to) return edge_w[i];
    end
    return INF_COST;
  endfunction

  function automatic void visit(logic [15:0] node, logic [15:0] cost, int hops,
                                logic [15:0] first);
    int idx;
    idx = find_heard(node);
    if (idx < 0 || best_c[idx] <= cost || stk_depth >= NODES) return;
    best_c[idx] = cost;
    best_h[idx] = hops & 63;
    best_f[idx] = first;
    stk_node[stk_depth] = node;
    stk_cost[stk_depth] = cost;
    stk_hops[stk_depth] = hops;
    stk_first[stk_depth] = first;
    stk_cursor[stk_depth] = 0;
    stk_depth++;
  endfunction

  // Run the search; return its rough cycle cost, and queue route entries
  // when commit is set.
  function automatic int route_search(bit commit);
    int work;
    int e;
    int top;
    logic [16:0] sum;
    logic [15:0] nb;
    out_item_t r;
    bit reach;
    work = 0;
    for (int i = 0; i < NODES; i++) begin
      best_c[i] = INF_COST;
      best_h[i] = 0;
      best_f[i] = '0;
    end
    stk_depth = 0;
    visit(self_addr, 16'd0, 0, 16'd0);
    while (stk_depth > 0) begin
      top = stk_depth - 1;
      e = stk_cursor[top];
      while (e < edge_total && edge_src[e] != stk_node[top]) e++;
      work += e - stk_cursor[top] + 1;
      if (e >= edge_total) begin
        stk_depth--;
      end else begin
        stk_cursor[top] = e + 1;
        nb = edge_dst[e];
        work += edge_total;
        sum = {1'b0, stk_cost[top]} + {1'b0, pair_weight(stk_node[top], nb)};
        if (sum > {1'b0, INF_COST}) sum = {1'b0, INF_COST};
        visit(nb, sum[15:0], stk_hops[top] + 1,
              (stk_hops[top] == 0) ? nb : stk_first[top]);
      end
    end
    if (commit) begin
      for (int i = 0; i < heard_total; i++) begin
        reach = (best_c[i] != INF_COST);
        r = '0;
        r.result_kind = 1'b1;
        r.status = ST_OK;
        r.dest_addr = heard_at(i);
        r.path_cost = best_c[i];
        r.hop_total = reach ? best_h[i][5:0] : 6'd0;
        r.first_hop = (reach && best_h[i] != 0) ? best_f[i] : 16'd0;
        r.last = (i + 1 == heard_total);
        expected_results.push_back(r);
      end
    end
    return work;
  endfunction

  function automatic void push_verdict(logic [2:0] st, logic [15:0] mask);
    out_item_t r;
    r = '0;
    r.status = st;
    r.forward_mask = mask;
    expected_results.push_back(r);
  endfunction

  function automatic void append_edge(logic [15:0] src, logic [15:0] dst, logic [15:0] w);
    if (edge_total >= EDGES) begin
      push_verdict(ST_FULL, 16'd0);
      return;
    end
    edge_src[edge_total] = src;
    edge_dst[edge_total] = dst;
    edge_w[edge_total] = w;
    edge_total++;
    push_verdict(ST_OK, 16'd0);
  endfunction

  function automatic void predict_item(in_item_t it);
    int ports;
    logic [15:0] mask;
    ports = (port_count > PORTS) ? PORTS : int'(port_count);
    case (it.kind)
      KIND_LOCAL: begin
        lsa_is_open = 1'b0;
        append_edge(self_addr, it.peer_addr, it.link_cost);
      end
      KIND_LINK: begin
        if (lsa_is_open) append_edge(lsa_sender, it.peer_addr, it.link_cost);
      end
      KIND_HEADER: begin
        lsa_is_open = 1'b0;
        if (it.peer_addr == self_addr) push_verdict(ST_OWN, 16'd0);
        else if (find_heard(it.peer_addr) >= 0) push_verdict(ST_HEARD, 16'd0);
        else if (int'(it.port) >= ports) push_verdict(ST_PORT, 16'd0);
        else if (heard_total >= NODES) push_verdict(ST_FULL, 16'd0);
        else begin
          heard[heard_total] = it.peer_addr;
          heard_total++;
          lsa_is_open = 1'b1;
          lsa_sender = it.peer_addr;
          mask = '0;
          for (int i = 0; i < ports; i++) begin
            if (i != int'(it.port)) mask[i] = 1'b1;
          end
          push_verdict(ST_OK, mask);
        end
      end
      default: begin
        lsa_is_open = 1'b0;
        void'(route_search(1'b1));
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Send one item; the transfer happens at the first edge with ready high.
  task automatic send_item(in_item_t it);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(it);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_fields(logic [1:0] k, logic [3:0] p, logic [15:0] a, logic [15:0] c);
    in_item_t it;
    it.kind = k;
    it.port = p;
    it.peer_addr = a;
    it.link_cost = c;
    send_item(it);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk);
    // an ignored link or late scan may still be in flight
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SELF) self_addr = value;
    else port_count = value[4:0];
  endtask

  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (r < 8) return self_addr;
    if (r < 18) return 16'($urandom);
    if (r < 24) return (r[0]) ? 16'hFFFF : 16'h0000;
    return 16'h0100 + 16'($urandom_range(39));
  endfunction

  function automatic logic [15:0] pick_cost();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'hFFFF;
    if (r < 10) return 16'h0000;
    if (r < 25) return 16'($urandom);
    return 16'($urandom_range(1, 200));
  endfunction

  // Compute only while the search stays affordable; otherwise add a local link.
  task automatic send_compute_or_link();
    if (route_search(1'b0) < SEARCH_BUDGET)
      send_fields(KIND_COMPUTE, 4'($urandom_range(15)), 16'($urandom), 16'($urandom));
    else
      send_fields(KIND_LOCAL, 4'($urandom_range(15)), pick_addr(), 16'($urandom));
  endtask

  // Checker, receiver stalls and watchdog
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      cycle_count <= 0;
      quiet_cycles <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count < hold_until) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_link_state_route_engine NOT OK");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", got.dest_addr, 16'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.result_kind !== want.result_kind)
            report_mismatch("result_kind", 16'(got.result_kind), 16'(want.result_kind));
          if (got.status !== want.status)
            report_mismatch("status", 16'(got.status), 16'(want.status));
          if (got.forward_mask !== want.forward_mask)
            report_mismatch("forward_mask", got.forward_mask, want.forward_mask);
          if (got.dest_addr !== want.dest_addr)
            report_mismatch("dest_addr", got.dest_addr, want.dest_addr);
          if (got.path_cost !== want.path_cost)
            report_mismatch("path_cost", got.path_cost, want.path_cost);
          if (got.hop_total !== want.hop_total)
            report_mismatch("hop_total", 16'(got.hop_total), 16'(want.hop_total));
          if (got.first_hop !== want.first_hop)
            report_mismatch("first_hop", got.first_hop, want.first_hop);
          if (got.last !== want.last)
            report_mismatch("last", 16'(got.last), 16'(want.last));
        end
      end
    end
  end

  task automatic test_directed();
    write_reg(CFG_SELF, 16'h0001);
    write_reg(CFG_PORTS, 16'd16);
    send_fields(KIND_COMPUTE, 4'd0, 16'd0, 16'd0);
    send_fields(KIND_LINK, 4'd0, 16'h0002, 16'd5);       // no open LSA: ignored
    send_fields(KIND_LOCAL, 4'd0, 16'h0002, 16'd0);
    send_fields(KIND_HEADER, 4'd3, 16'h0001, 16'd0);     // own LSA
    send_fields(KIND_HEADER, 4'd0, 16'h0002, 16'd0);
    send_fields(KIND_LINK, 4'd0, 16'h0003, 16'hFFFF);
    send_fields(KIND_LINK, 4'd0, 16'h0001, 16'd7);
    send_fields(KIND_HEADER, 4'd15, 16'h0002, 16'd0);    // already heard
    send_fields(KIND_LINK, 4'd0, 16'h0004, 16'd1);       // LSA closed
    send_fields(KIND_HEADER, 4'd15, 16'h0003, 16'hFFFF);
    send_fields(KIND_LINK, 4'd15, 16'hFFFF, 16'd1);
    send_fields(KIND_LINK, 4'd15, 16'h0002, 16'd1);
    send_fields(KIND_LOCAL, 4'd15, 16'h0003, 16'd2);
    send_fields(KIND_HEADER, 4'd7, 16'hFFFF, 16'd0);
    send_fields(KIND_LINK, 4'd0, 16'h0000, 16'd3);
    send_fields(KIND_COMPUTE, 4'd15, 16'hFFFF, 16'hFFFF);
    wait_drained();
    write_reg(CFG_PORTS, 16'd0);
    send_fields(KIND_HEADER, 4'd0, 16'h0010, 16'd0);     // bad port
    wait_drained();
    write_reg(CFG_PORTS, 16'd31);
    write_reg(CFG_SELF, 16'hFFFF);
    send_fields(KIND_HEADER, 4'd15, 16'hFFFF, 16'd0);    // own LSA at new address
    send_fields(KIND_HEADER, 4'd15, 16'h0011, 16'd0);
    send_fields(KIND_LINK, 4'd0, 16'h0001, 16'd9);
    send_fields(KIND_COMPUTE, 4'd0, 16'd0, 16'd0);
    wait_drained();
  endtask

  task automatic random_phase(int count, logic [15:0] self_val, logic [4:0] ports_val);
    int sent;
    int r;
    int links;
    write_reg(CFG_SELF, self_val);
    write_reg(CFG_PORTS, 16'(ports_val));
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_fields(KIND_HEADER, 4'($urandom_range(15)), pick_addr(), 16'($urandom));
        links = $urandom_range(0, 4);
        for (int i = 0; i < links; i++)
          send_fields(KIND_LINK, 4'($urandom_range(15)), pick_addr(), pick_cost());
        sent += links + 1;
      end else if (r < 75) begin
        send_fields(KIND_LOCAL, 4'($urandom_range(15)), pick_addr(), pick_cost());
        sent++;
      end else if (r < 83) begin
        send_compute_or_link();
        sent++;
      end else begin
        send_fields(KIND_LINK, 4'($urandom_range(15)), 16'($urandom), 16'($urandom));
        sent++;
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_until = cycle_count + 500;
    for (int i = 0; i < 12; i++)
      send_fields(KIND_LOCAL, 4'($urandom_range(15)), pick_addr(), pick_cost());
    send_compute_or_link();
    wait_drained();
  endtask

  task automatic test_table_limits();
    int n;
    n = 0;
    while (heard_total < NODES && n < 200) begin
      send_fields(KIND_HEADER, 4'd0, 16'h4000 + 16'(n), 16'd0);
      n++;
    end
    send_fields(KIND_HEADER, 4'd0, 16'h5000, 16'd0);     // heard table full
    while (edge_total < EDGES)
      send_fields(KIND_LOCAL, 4'd1, pick_addr(), pick_cost());
    send_fields(KIND_LOCAL, 4'd2, 16'h0101, 16'd1);      // edge table full
    send_fields(KIND_HEADER, 4'd0, 16'h0001, 16'd0);
    send_compute_or_link();
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SELF;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    self_addr = '0;
    port_count = '0;
    edge_total = 0;
    heard_total = 1;
    lsa_is_open = 1'b0;
    lsa_sender = '0;
    for (int i = 0; i < NODES; i++) heard[i] = '0;
    mismatches = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_until = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    send_gap_pct = 13;
    recv_stall_pct = 62;
    random_phase(25, 16'h0000, 5'd5);
    send_gap_pct = 62;
    recv_stall_pct = 13;
    random_phase(25, 16'h0105, 5'd16);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    random_phase(25, 16'hFFFF, 5'd31);
    test_table_limits();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_link_state_route_engine OK");
    end else begin
      $display("tb_link_state_route_engine NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/lsre_pkg.sv
design/lsre_stream_if.sv
design/lsre_front.sv
design/lsre_back.sv
design/link_state_route_engine.sv
design/lsre_checker.sv
tb/sv/tb_link_state_route_engine.sv
